[sv/sfv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_pkg
// Shared constants, command codes and types for the segment facet visibility
// unit.
// ----------------------------------------------------------------------------
package sfv_pkg;

    localparam int MAX_FACETS_DEF = 64;
    localparam int COORD_BITS_DEF = 24;

    localparam int ACTION_W  = 2;
    localparam int SLOT_W    = 6;
    localparam int BLOCKER_W = 6;
    localparam int THR_W     = 50;
    localparam int FCOUNT_W  = 7;
    localparam int OP_W      = 2;

    // input actions
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PATH   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FACET  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_FACET_COUNT = 2'd1;

    // commands passed from the front end to the back end
    localparam logic [OP_W-1:0] OP_LOAD        = 2'd0;
    localparam logic [OP_W-1:0] OP_PATH_FIRST  = 2'd1;
    localparam logic [OP_W-1:0] OP_FACET_FIRST = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
    } cmd_t;

endpackage
`default_nettype wire

[sv/sfv_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_front
// Input side: accepts transactions, decodes the action, drops unknown actions
// and out-of-range loads, and pushes commands into the queue.
// ----------------------------------------------------------------------------
module sfv_front
    import sfv_pkg::*;
#(
    parameter int MAX_FACETS = MAX_FACETS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                      item_valid,
    output      logic                      item_stall,
    input  wire logic [ACTION_W-1:0]       action,
    input  wire logic [SLOT_W-1:0]         facet_index,
    input  wire logic [COORD_BITS-1:0]     start_x,
    input  wire logic [COORD_BITS-1:0]     start_y,
    input  wire logic [COORD_BITS-1:0]     end_x,
    input  wire logic [COORD_BITS-1:0]     end_y,
    input  wire logic                      q_full,
    output      logic                      q_push,
    output      cmd_t                      q_cmd,
    output      logic [4*COORD_BITS-1:0]   q_coords
);

    localparam int CNT_W = $clog2(MAX_FACETS + 1);
    localparam int CMP_W = (CNT_W > SLOT_W + 1) ? CNT_W : SLOT_W + 1;

    logic accept;
    logic slot_ok;
    logic keep;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;
    assign slot_ok    = CMP_W'(facet_index) < CMP_W'(MAX_FACETS);

    always_comb
    begin
        keep  = 1'b0;
        q_cmd = '{op: OP_LOAD, slot: facet_index};
        unique case (action)
            ACT_LOAD:
            begin
                keep     = slot_ok;
                q_cmd.op = OP_LOAD;
            end
            ACT_PATH:
            begin
                keep     = 1'b1;
                q_cmd.op = OP_PATH_FIRST;
            end
            ACT_FACET:
            begin
                keep     = 1'b1;
                q_cmd.op = OP_FACET_FIRST;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push   = accept && keep;
    assign q_coords = {start_x, start_y, end_x, end_y};

endmodule
`default_nettype wire

[sv/sfv_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_queue
// Two-entry command queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module sfv_queue
    import sfv_pkg::*;
#(
    parameter int W = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output      logic         full,
    input  wire logic         pop,
    output      logic         pop_valid,
    output      logic [W-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [W-1:0] entry_reg [DEPTH];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    assign full      = count_reg == 2'(DEPTH);
    assign pop_valid = count_reg != 2'd0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[sv/sfv_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfv_back
// Execution side: owns the facet memory, performs loads, and walks the facets
// for a query through a five-stage read/difference/multiply/cross/compare
// pipeline, one facet per cycle. Holds the result register.
// ----------------------------------------------------------------------------
module sfv_back
    import sfv_pkg::*;
#(
    parameter int MAX_FACETS = MAX_FACETS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    input  wire cmd_t                    q_cmd,
    input  wire logic [4*COORD_BITS-1:0] q_coords,
    output      logic                    q_pop,
    input  wire logic [THR_W-1:0]        threshold,
    input  wire logic [FCOUNT_W-1:0]     facet_count,
    output      logic                    result_valid,
    input  wire logic                    result_stall,
    output      logic                    visible,
    output      logic [BLOCKER_W-1:0]    blocker
);

    localparam int C     = COORD_BITS;
    localparam int SEG_W = 4 * C;
    localparam int DW    = C + 1;
    localparam int PW    = 2 * DW;
    localparam int XW    = PW + 1;
    localparam int KW    = ((XW > THR_W + 1) ? XW : THR_W + 1) + 1;
    localparam int IDX_W = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1;
    localparam int CNT_W = $clog2(MAX_FACETS + 1);
    localparam int CMP_W = (CNT_W > FCOUNT_W) ? CNT_W : FCOUNT_W;
    localparam int BW    = (IDX_W > BLOCKER_W) ? IDX_W : BLOCKER_W;
    localparam int SW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // difference vector slots
    localparam int AB0 = 0;
    localparam int AB1 = 1;
    localparam int PQ0 = 2;
    localparam int PQ1 = 3;
    localparam int AP0 = 4;
    localparam int AP1 = 5;
    localparam int AQ0 = 6;
    localparam int AQ1 = 7;
    localparam int PB0 = 8;
    localparam int PB1 = 9;
    localparam int PA0 = 10;
    localparam int PA1 = 11;

    function automatic logic [DW-1:0] sdiff(input logic [C-1:0] a, input logic [C-1:0] b);
        sdiff = {a[C-1], a} - {b[C-1], b};
    endfunction

    logic [SEG_W-1:0]         facet_mem [MAX_FACETS];

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic                     facet_first_reg;
    logic [SEG_W-1:0]         qseg_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         issue_reg;
    logic [CNT_W-1:0]         issue_next;
    logic [CNT_W-1:0]         ret_reg;
    logic [CNT_W-1:0]         ret_next;
    logic [CNT_W-1:0]         ret_inc;
    logic                     res_vis_reg;
    logic                     res_vis_next;
    logic [BLOCKER_W-1:0]     res_blk_reg;
    logic [BLOCKER_W-1:0]     res_blk_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     vis_reg;
    logic [BLOCKER_W-1:0]     blk_reg;

    logic                     start;
    logic                     wr_en;
    logic                     rd_en;
    logic                     out_load;
    logic                     kill;
    logic [IDX_W-1:0]         wr_addr;
    logic [IDX_W-1:0]         rd_addr;
    logic [SW-1:0]            slot_wide;
    logic [BW-1:0]            blk_wide;
    logic [CMP_W-1:0]         n_wide;
    logic [CNT_W-1:0]         n_cfg;

    // pipeline
    logic [SEG_W-1:0]         rdat_reg;
    logic                     v1_reg;
    logic [IDX_W-1:0]         i1_reg;
    logic signed [DW-1:0]     dif_reg [12];
    logic                     v2_reg;
    logic [IDX_W-1:0]         i2_reg;
    logic signed [PW-1:0]     prod_reg [10];
    logic                     v3_reg;
    logic [IDX_W-1:0]         i3_reg;
    logic signed [XW-1:0]     cr_reg [5];
    logic                     v4_reg;
    logic [IDX_W-1:0]         i4_reg;
    logic                     hit_reg;
    logic                     v5_reg;
    logic [IDX_W-1:0]         i5_reg;

    logic [SEG_W-1:0]         s_vec;
    logic [SEG_W-1:0]         t_vec;
    logic [C-1:0]             sax, say, sbx, sby, tax, tay, tbx, tby;
    logic [KW-1:0]            thr_ext;
    logic [KW-1:0]            c_ext [5];
    logic [KW-1:0]            c_sum [5];
    logic [4:0]               below_pos;
    logic [4:0]               below_neg;
    logic                     flip;
    logic                     hit;

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    assign n_wide    = (CMP_W'(facet_count) > CMP_W'(MAX_FACETS)) ?
                       CMP_W'(MAX_FACETS) : CMP_W'(facet_count);
    assign n_cfg     = n_wide[CNT_W-1:0];
    assign slot_wide = SW'(q_cmd.slot);
    assign wr_addr   = slot_wide[IDX_W-1:0];
    assign rd_addr   = issue_reg[IDX_W-1:0];
    assign ret_inc   = ret_reg + CNT_W'(1);
    assign blk_wide  = BW'(i5_reg);

    always_comb
    begin
        state_next   = state_reg;
        q_pop        = 1'b0;
        wr_en        = 1'b0;
        start        = 1'b0;
        rd_en        = 1'b0;
        out_load     = 1'b0;
        issue_next   = issue_reg;
        ret_next     = ret_reg;
        res_vis_next = res_vis_reg;
        res_blk_next = res_blk_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op) inside
                        OP_LOAD:
                        begin
                            wr_en = 1'b1;
                        end
                        OP_PATH_FIRST, OP_FACET_FIRST:
                        begin
                            start      = 1'b1;
                            issue_next = '0;
                            ret_next   = '0;
                            if (n_cfg == '0)
                            begin
                                res_vis_next = 1'b1;
                                res_blk_next = '0;
                                state_next   = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                rd_en = issue_reg < n_reg;
                if (rd_en)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (v5_reg)
                begin
                    ret_next = ret_inc;
                    if (hit_reg)
                    begin
                        res_vis_next = 1'b0;
                        res_blk_next = blk_wide[BLOCKER_W-1:0];
                        state_next   = ST_DONE;
                    end
                    else if (ret_inc == n_reg)
                    begin
                        res_vis_next = 1'b1;
                        res_blk_next = '0;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // drop everything still in flight once the walk ends
    assign kill = state_next != ST_RUN;

    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= '0;
            ret_reg       <= '0;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            v1_reg        <= rd_en && !kill;
            v2_reg        <= v1_reg && !kill;
            v3_reg        <= v2_reg && !kill;
            v4_reg        <= v3_reg && !kill;
            v5_reg        <= v4_reg && !kill;
        end
    end

    always_ff @(posedge clk)
    begin
        res_vis_reg <= res_vis_next;
        res_blk_reg <= res_blk_next;
        if (start)
        begin
            qseg_reg        <= q_coords;
            facet_first_reg <= q_cmd.op == OP_FACET_FIRST;
            n_reg           <= n_cfg;
        end
        if (out_load)
        begin
            vis_reg <= res_vis_reg;
            blk_reg <= res_blk_reg;
        end
    end

    // ------------------------------------------------------------------
    // facet memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            facet_mem[wr_addr] <= q_coords;
        end
        if (rd_en)
        begin
            rdat_reg <= facet_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // stage D: endpoint differences
    // ------------------------------------------------------------------
    assign s_vec = facet_first_reg ? rdat_reg : qseg_reg;
    assign t_vec = facet_first_reg ? qseg_reg : rdat_reg;
    assign sax   = s_vec[4*C-1:3*C];
    assign say   = s_vec[3*C-1:2*C];
    assign sbx   = s_vec[2*C-1:C];
    assign sby   = s_vec[C-1:0];
    assign tax   = t_vec[4*C-1:3*C];
    assign tay   = t_vec[3*C-1:2*C];
    assign tbx   = t_vec[2*C-1:C];
    assign tby   = t_vec[C-1:0];

    always_ff @(posedge clk)
    begin
        i1_reg       <= rd_addr;
        i2_reg       <= i1_reg;
        i3_reg       <= i2_reg;
        i4_reg       <= i3_reg;
        i5_reg       <= i4_reg;
        dif_reg[AB0] <= sdiff(sbx, sax);
        dif_reg[AB1] <= sdiff(sby, say);
        dif_reg[PQ0] <= sdiff(tbx, tax);
        dif_reg[PQ1] <= sdiff(tby, tay);
        dif_reg[AP0] <= sdiff(tax, sax);
        dif_reg[AP1] <= sdiff(tay, say);
        dif_reg[AQ0] <= sdiff(tbx, sax);
        dif_reg[AQ1] <= sdiff(tby, say);
        dif_reg[PB0] <= sdiff(sbx, tax);
        dif_reg[PB1] <= sdiff(sby, tay);
        dif_reg[PA0] <= sdiff(sax, tax);
        dif_reg[PA1] <= sdiff(say, tay);
    end

    // ------------------------------------------------------------------
    // stage M: products, stage X: cross products
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg[0] <= dif_reg[AB0] * dif_reg[PQ1];
        prod_reg[1] <= dif_reg[AB1] * dif_reg[PQ0];
        prod_reg[2] <= dif_reg[AP0] * dif_reg[AB1];
        prod_reg[3] <= dif_reg[AP1] * dif_reg[AB0];
        prod_reg[4] <= dif_reg[AB0] * dif_reg[AQ1];
        prod_reg[5] <= dif_reg[AB1] * dif_reg[AQ0];
        prod_reg[6] <= dif_reg[PB0] * dif_reg[PQ1];
        prod_reg[7] <= dif_reg[PB1] * dif_reg[PQ0];
        prod_reg[8] <= dif_reg[PQ0] * dif_reg[PA1];
        prod_reg[9] <= dif_reg[PQ1] * dif_reg[PA0];
        for (int k = 0; k < 5; k++)
        begin
            cr_reg[k] <= {prod_reg[2*k][PW-1], prod_reg[2*k]}
                       - {prod_reg[2*k+1][PW-1], prod_reg[2*k+1]};
        end
    end

    // ------------------------------------------------------------------
    // stage C: threshold compares. Negating both direction vectors negates
    // every later cross product, so -c < thr is tested as c + thr > 0.
    // ------------------------------------------------------------------
    assign thr_ext = {{(KW-THR_W){1'b0}}, threshold};

    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            c_ext[k]     = {{(KW-XW){cr_reg[k][XW-1]}}, cr_reg[k]};
            c_sum[k]     = c_ext[k] + thr_ext;
            below_pos[k] = $signed(c_ext[k]) < $signed(thr_ext);
            below_neg[k] = !c_sum[k][KW-1] && (c_sum[k] != '0);
        end
        flip = below_pos[0];
        hit  = flip ? (below_neg[4:1] == 4'd0) : (below_pos[4:1] == 4'd0);
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit;
    end

    assign result_valid = out_valid_reg;
    assign visible      = vis_reg;
    assign blocker      = blk_reg;

`ifndef SYNTHESIS
    a_result_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> state_reg == ST_RUN)
        else $error("facet result emerged outside a walk");

    a_walk_counts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> (issue_reg <= n_reg) && (ret_reg <= issue_reg))
        else $error("walk counters out of order");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> n_reg != '0)
        else $error("walk started with no facets");

    a_visible_blocker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && vis_reg |-> blk_reg == '0)
        else $error("visible result carries a blocker");

    a_load_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == ST_IDLE && !v1_reg)
        else $error("facet load during a walk");
`endif

endmodule
`default_nettype wire

[sv/segment_facet_visibility_unit.sv]
`default_nettype none
// Load transaction: queued, then written to facet memory; one load per cycle while no query runs.
// Query: walks n = min(facet_count, MAX_FACETS) facets, stopping early when a blocking facet
// is found; one memory read per facet. With n of 0 the result is visible without a walk.
// Queries run one at a time; the next starts once the previous result is loaded for output.
// A two-entry queue lets the input side keep accepting while the walk runs.
// Reset (rst_n, async): threshold 1, facet_count 0, queue and pipeline empty, facets undefined.
// ----------------------------------------------------------------------------
// segment_facet_visibility_unit
// Facet table with segment crossing queries: front end, command queue, back
// end with facet memory and crossing-test pipeline, configuration registers.
// ----------------------------------------------------------------------------
module segment_facet_visibility_unit
    import sfv_pkg::*;
#(
    parameter int MAX_FACETS = MAX_FACETS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output      logic                  item_stall,
    input  wire logic [ACTION_W-1:0]   action,
    input  wire logic [SLOT_W-1:0]     facet_index,
    input  wire logic [COORD_BITS-1:0] start_x,
    input  wire logic [COORD_BITS-1:0] start_y,
    input  wire logic [COORD_BITS-1:0] end_x,
    input  wire logic [COORD_BITS-1:0] end_y,
    output      logic                  result_valid,
    input  wire logic                  result_stall,
    output      logic                  visible,
    output      logic [BLOCKER_W-1:0]  blocker,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [THR_W-1:0]      cfg_data
);

    localparam int         QW = $bits(cmd_t) + 4 * COORD_BITS;

    logic [THR_W-1:0]          thr_reg;
    logic [THR_W-1:0]          thr_next;
    logic [FCOUNT_W-1:0]       fcount_reg;
    logic [FCOUNT_W-1:0]       fcount_next;

    logic                      q_full;
    logic                      q_push;
    cmd_t                      push_cmd;
    logic [4*COORD_BITS-1:0]   push_coords;
    logic                      q_pop;
    logic                      q_valid;
    logic [QW-1:0]             q_data;
    cmd_t                      pop_cmd;
    logic [4*COORD_BITS-1:0]   pop_coords;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        thr_next    = thr_reg;
        fcount_next = fcount_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:   thr_next    = cfg_data;
                REG_FACET_COUNT: fcount_next = cfg_data[FCOUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_W'(1);
            fcount_reg <= '0;
        end
        else
        begin
            thr_reg    <= thr_next;
            fcount_reg <= fcount_next;
        end
    end

    sfv_front #(
        .MAX_FACETS (MAX_FACETS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .action      (action),
        .facet_index (facet_index),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd),
        .q_coords    (push_coords)
    );

    sfv_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_cmd, push_coords}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    assign pop_cmd    = q_data[QW-1:4*COORD_BITS];
    assign pop_coords = q_data[4*COORD_BITS-1:0];

    sfv_back #(
        .MAX_FACETS (MAX_FACETS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (pop_cmd),
        .q_coords     (pop_coords),
        .q_pop        (q_pop),
        .threshold    (thr_reg),
        .facet_count  (fcount_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .visible      (visible),
        .blocker      (blocker)
    );

endmodule
`default_nettype wire
